[src/sslim_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslim_pkg
// Shared widths, constants and types of the soft saturation limiter.
// ----------------------------------------------------------------------------
package sslim_pkg;

  localparam int SAMPLE_FRAC_BITS = 8;
  localparam int RATIO_FRAC_BITS  = 16;

  localparam int SAMPLE_W = 24;
  localparam int MAG_W    = 24;
  localparam int THR_W    = 16;
  localparam int HC_W     = 12;
  localparam int HQ_W     = 16;
  localparam int TQ_W     = 24;
  localparam int XQ_W     = 28;
  localparam int K_W      = RATIO_FRAC_BITS + 1;
  localparam int R_W      = 39;
  localparam int RR_W     = RATIO_FRAC_BITS;
  localparam int INV_W    = RATIO_FRAC_BITS + 1;
  localparam int Y_W      = RATIO_FRAC_BITS + 1;
  localparam int N_W      = HC_W + RATIO_FRAC_BITS;

  // Divider geometry: one quotient bit per stage.
  localparam int NUM_W      = 44;
  localparam int DEN_W      = 40;
  localparam int DIV_STAGES = NUM_W;

  localparam int TQ_SHIFT = SAMPLE_FRAC_BITS + RATIO_FRAC_BITS + 1;

  localparam logic [RATIO_FRAC_BITS:0] ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

  localparam logic [THR_W-1:0] THR_MIN  = 16'd16;
  localparam logic [THR_W-1:0] THR_MAX  = 16'd32768;
  localparam logic [HC_W-1:0]  HC_MIN   = 12'd1;
  localparam logic [HC_W-1:0]  HC_MAX   = 12'd2048;
  localparam logic [N_W-1:0]   HARD_DIV = 28'd2049;

  // Reciprocal of the hardness divisor for the knee position.
  localparam int               HQ_SHIFT = 40;
  localparam int               RECIP_W  = 30;
  localparam int               PROD_W   = N_W + RECIP_W;
  localparam logic [RECIP_W-1:0] HQ_RECIP = RECIP_W'((64'd1 << HQ_SHIFT) / 64'd2049);

  localparam logic [MAG_W:0] POS_LIMIT = 25'h07FFFFF;
  localparam logic [MAG_W:0] NEG_LIMIT = 25'h0800000;

  // Configuration register indexes.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_HARDNESS  = 1'b1;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;

  typedef struct packed {
    logic             neg;
    logic             last;
    logic [MAG_W-1:0] mag;
    logic [THR_W-1:0] thr;
    logic [HQ_W-1:0]  hq;
  } item_t;

  typedef struct packed {
    logic             neg;
    logic             last;
    logic [MAG_W-1:0] mag;
    logic [HQ_W-1:0]  hq;
    logic [TQ_W-1:0]  tq;
    logic [XQ_W-1:0]  xq;
    logic             knee;
    logic [XQ_W-1:0]  d;
    logic [K_W-1:0]   k;
    logic [R_W-1:0]   r;
    logic [RR_W-1:0]  rr;
    logic             big;
  } side_t;

endpackage

[src/sslim_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslim_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module sslim_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  sslim_pkg::num_t      in_num,
  input  sslim_pkg::den_t      in_den,
  input  sslim_pkg::side_t     in_tag,
  output logic                 out_valid,
  output sslim_pkg::num_t      out_quo,
  output sslim_pkg::side_t     out_tag
);

  localparam int N  = sslim_pkg::DIV_STAGES;
  localparam int NW = sslim_pkg::NUM_W;
  localparam int DW = sslim_pkg::DEN_W;

  logic             st_v   [N];
  sslim_pkg::num_t  st_nq  [N];
  sslim_pkg::den_t  st_rm  [N];
  sslim_pkg::den_t  st_dn  [N];
  sslim_pkg::side_t st_tag [N];

  genvar g;
  for (g = 0; g < N; g++) begin : g_stage
    logic             cur_v;
    sslim_pkg::num_t  cur_nq;
    sslim_pkg::den_t  cur_rm;
    sslim_pkg::den_t  cur_dn;
    sslim_pkg::side_t cur_tag;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             fit;

    if (g == 0) begin : g_first
      assign cur_v   = in_valid;
      assign cur_nq  = in_num;
      assign cur_rm  = '0;
      assign cur_dn  = in_den;
      assign cur_tag = in_tag;
    end else begin : g_next
      assign cur_v   = st_v[g-1];
      assign cur_nq  = st_nq[g-1];
      assign cur_rm  = st_rm[g-1];
      assign cur_dn  = st_dn[g-1];
      assign cur_tag = st_tag[g-1];
    end

    // Shift in the next numerator bit and try the subtract.
    assign trial = {cur_rm, cur_nq[NW-1]};
    assign diff  = trial - {1'b0, cur_dn};
    assign fit   = ~diff[DW];

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[g] <= 1'b0;
      end else begin
        st_v[g] <= cur_v;
      end
      st_nq[g]  <= {cur_nq[NW-2:0], fit};
      st_rm[g]  <= fit ? diff[DW-1:0] : trial[DW-1:0];
      st_dn[g]  <= cur_dn;
      st_tag[g] <= cur_tag;
    end
  end

  assign out_valid = st_v[N-1];
  assign out_quo   = st_nq[N-1];
  assign out_tag   = st_tag[N-1];

endmodule

[src/sslim_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslim_queue
// Two-entry queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module sslim_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sslim_pkg::item_t push_item,
  input  logic             pop,
  output logic             full,
  output logic             valid,
  output sslim_pkg::item_t head
);

  sslim_pkg::item_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

[src/sslim_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslim_front
// Accepts samples, takes the magnitude and sign, clamps the settings and
// derives the knee position.
// ----------------------------------------------------------------------------
module sslim_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   q_full,
  input  logic signed [sslim_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic                                   last_in,
  input  logic [sslim_pkg::THR_W-1:0]            threshold_level,
  input  logic [sslim_pkg::HC_W-1:0]             hardness_code,
  output logic                                   push,
  output sslim_pkg::item_t                       push_item
);

  localparam int NW = sslim_pkg::N_W;
  localparam int HW = sslim_pkg::HQ_W;

  logic                            accept;
  logic [sslim_pkg::THR_W-1:0]     thr_c;
  logic [sslim_pkg::HC_W-1:0]      hc_c;
  logic [NW-1:0]                   n;
  logic [sslim_pkg::MAG_W-1:0]     mag;

  logic                            f1_v;
  logic                            f1_neg;
  logic                            f1_last;
  logic [sslim_pkg::MAG_W-1:0]     f1_mag;
  logic [sslim_pkg::THR_W-1:0]     f1_thr;
  logic [NW-1:0]                   f1_n;
  logic [sslim_pkg::PROD_W-1:0]    f1_prod;

  logic [HW-1:0]                   q0;
  logic [NW-1:0]                   qm;
  logic [NW-1:0]                   rem;

  assign accept = start && !q_full;

  always_comb begin
    if (threshold_level < sslim_pkg::THR_MIN) begin
      thr_c = sslim_pkg::THR_MIN;
    end else if (threshold_level > sslim_pkg::THR_MAX) begin
      thr_c = sslim_pkg::THR_MAX;
    end else begin
      thr_c = threshold_level;
    end
    if (hardness_code < sslim_pkg::HC_MIN) begin
      hc_c = sslim_pkg::HC_MIN;
    end else if (hardness_code > sslim_pkg::HC_MAX) begin
      hc_c = sslim_pkg::HC_MAX;
    end else begin
      hc_c = hardness_code;
    end
  end

  assign n   = {hc_c, {sslim_pkg::RATIO_FRAC_BITS{1'b0}}};
  assign mag = sample_in[sslim_pkg::SAMPLE_W-1] ? (~sample_in + 24'd1) : sample_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else begin
      f1_v <= accept;
    end
    if (accept) begin
      f1_neg  <= sample_in[sslim_pkg::SAMPLE_W-1];
      f1_last <= last_in;
      f1_mag  <= mag;
      f1_thr  <= thr_c;
      f1_n    <= n;
      f1_prod <= sslim_pkg::PROD_W'(n) * sslim_pkg::PROD_W'(sslim_pkg::HQ_RECIP);
    end
  end

  // Reciprocal estimate is low by at most one; correct with the remainder.
  assign q0  = HW'(f1_prod >> sslim_pkg::HQ_SHIFT);
  assign qm  = (NW'(q0) << 11) + NW'(q0);
  assign rem = f1_n - qm;

  assign push = f1_v;

  always_comb begin
    push_item.neg  = f1_neg;
    push_item.last = f1_last;
    push_item.mag  = f1_mag;
    push_item.thr  = f1_thr;
    push_item.hq   = (rem >= sslim_pkg::HARD_DIV) ? q0 + 16'd1 : q0;
  end

endmodule

[src/sslim_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sslim_back
// Arithmetic pipeline: scale, ratio, knee curve, ceiling and rescale.
// ----------------------------------------------------------------------------
module sslim_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  sslim_pkg::item_t                       in_item,
  output logic                                   out_valid,
  output logic signed [sslim_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                   out_last
);

  localparam int RFB = sslim_pkg::RATIO_FRAC_BITS;
  localparam int XW  = sslim_pkg::XQ_W;
  localparam int YW  = sslim_pkg::Y_W;
  localparam int TW  = sslim_pkg::TQ_W;
  localparam int PW  = YW + TW;
  localparam int MW  = sslim_pkg::MAG_W + 1;

  // scale t
  sslim_pkg::side_t t_in_tag, t_tag;
  sslim_pkg::num_t  t_num, t_quo;
  sslim_pkg::den_t  t_den;
  logic             t_v;

  // ratio x
  sslim_pkg::side_t x_in_tag, x_tag;
  sslim_pkg::num_t  x_num, x_quo;
  sslim_pkg::den_t  x_den;
  logic             x_v;

  // excess over knee, d/k
  sslim_pkg::side_t r_in_tag, r_tag;
  sslim_pkg::num_t  r_num, r_quo;
  sslim_pkg::den_t  r_den;
  logic             r_v;
  logic [XW-1:0]    xq;

  // square and reciprocal
  sslim_pkg::side_t m_in_tag, m_tag;
  logic             m_v;
  sslim_pkg::side_t i_tag;
  sslim_pkg::num_t  i_num, i_quo;
  sslim_pkg::den_t  i_den;
  logic             i_v;

  // curve division
  sslim_pkg::side_t s_tag, a_tag;
  sslim_pkg::num_t  s_num, a_quo;
  sslim_pkg::den_t  s_den;
  logic             s_v, a_v;

  // finish
  logic [XW-1:0]    yq_pre;
  logic [YW-1:0]    yq;
  logic             f1_v, f1_neg, f1_last;
  logic [YW-1:0]    f1_yq;
  logic [TW-1:0]    f1_tq;
  logic             f2_v, f2_neg, f2_last;
  logic [PW-1:0]    f2_prod;
  logic [MW-1:0]    m_mag;
  logic [MW-1:0]    m_neg_sat;
  logic [MW-1:0]    m_pos_sat;

  always_comb begin
    t_in_tag      = '0;
    t_in_tag.neg  = in_item.neg;
    t_in_tag.last = in_item.last;
    t_in_tag.mag  = in_item.mag;
    t_in_tag.hq   = in_item.hq;
  end
  assign t_num = sslim_pkg::num_t'(in_item.thr) << sslim_pkg::TQ_SHIFT;
  assign t_den = sslim_pkg::den_t'(sslim_pkg::ONE) + sslim_pkg::den_t'(in_item.hq);

  sslim_div u_div_t (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_num(t_num), .in_den(t_den),
    .in_tag(t_in_tag), .out_valid(t_v), .out_quo(t_quo), .out_tag(t_tag)
  );

  always_comb begin
    x_in_tag    = t_tag;
    x_in_tag.tq = t_quo[TW-1:0];
  end
  assign x_num = sslim_pkg::num_t'(t_tag.mag) << RFB;
  assign x_den = sslim_pkg::den_t'(t_quo[TW-1:0]);

  sslim_div u_div_x (
    .clk(clk), .rst(rst), .in_valid(t_v), .in_num(x_num), .in_den(x_den),
    .in_tag(x_in_tag), .out_valid(x_v), .out_quo(x_quo), .out_tag(x_tag)
  );

  assign xq = x_quo[XW-1:0];

  always_comb begin
    r_in_tag      = x_tag;
    r_in_tag.xq   = xq;
    r_in_tag.knee = xq > XW'(x_tag.hq);
    r_in_tag.d    = xq - XW'(x_tag.hq);
    r_in_tag.k    = sslim_pkg::ONE - sslim_pkg::K_W'(x_tag.hq);
  end
  assign r_num = sslim_pkg::num_t'(r_in_tag.d) << RFB;
  assign r_den = sslim_pkg::den_t'(r_in_tag.k);

  sslim_div u_div_r (
    .clk(clk), .rst(rst), .in_valid(x_v), .in_num(r_num), .in_den(r_den),
    .in_tag(r_in_tag), .out_valid(r_v), .out_quo(r_quo), .out_tag(r_tag)
  );

  always_comb begin
    m_in_tag     = r_tag;
    m_in_tag.r   = r_quo[sslim_pkg::R_W-1:0];
    m_in_tag.rr  = sslim_pkg::RR_W'((32'(r_quo[RFB-1:0]) * 32'(r_quo[RFB-1:0])) >> RFB);
    m_in_tag.big = |r_quo[sslim_pkg::R_W-1:RFB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else begin
      m_v <= r_v;
    end
    m_tag <= m_in_tag;
  end

  assign i_num = sslim_pkg::num_t'(1) << (2 * RFB);
  assign i_den = sslim_pkg::den_t'(m_tag.r);

  sslim_div u_div_i (
    .clk(clk), .rst(rst), .in_valid(m_v), .in_num(i_num), .in_den(i_den),
    .in_tag(m_tag), .out_valid(i_v), .out_quo(i_quo), .out_tag(i_tag)
  );

  // Above unit ratio the curve is k/(r+1/r); below it d/(1+r^2).
  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else begin
      s_v <= i_v;
    end
    s_tag <= i_tag;
    if (i_tag.knee && i_tag.big) begin
      s_num <= sslim_pkg::num_t'(i_tag.k) << RFB;
      s_den <= sslim_pkg::den_t'(i_tag.r) + sslim_pkg::den_t'(i_quo[sslim_pkg::INV_W-1:0]);
    end else begin
      s_num <= sslim_pkg::num_t'(i_tag.d) << RFB;
      s_den <= sslim_pkg::den_t'(sslim_pkg::ONE) + sslim_pkg::den_t'(i_tag.rr);
    end
  end

  sslim_div u_div_a (
    .clk(clk), .rst(rst), .in_valid(s_v), .in_num(s_num), .in_den(s_den),
    .in_tag(s_tag), .out_valid(a_v), .out_quo(a_quo), .out_tag(a_tag)
  );

  assign yq_pre = a_tag.knee ? XW'(a_tag.hq) + XW'(a_quo[YW-1:0]) : a_tag.xq;
  assign yq     = (yq_pre > XW'(sslim_pkg::ONE))
                ? YW'((sslim_pkg::ONE + YW'(a_tag.hq)) >> 1) : yq_pre[YW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else begin
      f1_v <= a_v;
      f2_v <= f1_v;
    end
    f1_neg  <= a_tag.neg;
    f1_last <= a_tag.last;
    f1_yq   <= yq;
    f1_tq   <= a_tag.tq;
    f2_neg  <= f1_neg;
    f2_last <= f1_last;
    f2_prod <= PW'(f1_yq) * PW'(f1_tq);
  end

  assign m_mag     = f2_prod[PW-1:RFB];
  assign m_neg_sat = (m_mag > sslim_pkg::NEG_LIMIT) ? sslim_pkg::NEG_LIMIT : m_mag;
  assign m_pos_sat = (m_mag > sslim_pkg::POS_LIMIT) ? sslim_pkg::POS_LIMIT : m_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= f2_v;
    end
    out_last   <= f2_last;
    out_sample <= f2_neg ? sslim_pkg::SAMPLE_W'(MW'(0) - m_neg_sat)
                         : sslim_pkg::SAMPLE_W'(m_pos_sat);
  end

endmodule

[src/soft_saturation_limiter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_saturation_limiter_unit
// Soft saturating limiter for signed Q16.8 audio samples.
// ----------------------------------------------------------------------------
// Takes one sample per clock and raises the one-cycle done strobe for each
// limited sample after its accepting edge, in order; the receiver cannot
// hold it off. The path runs through the five pipelined 44-stage dividers
// (scale, ratio, knee ratio, reciprocal, curve), each retiring one quotient
// bit per stage, and single register stages (front, queue, square, curve
// select, ceiling, product, output). busy stays low in normal use; settings
// written through the cfg port apply to samples started afterward.
module soft_saturation_limiter_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [sslim_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic                                   last_in,
  input  logic                                   cfg_wr_en,
  input  logic                                   cfg_index,
  input  logic [sslim_pkg::THR_W-1:0]            cfg_data,
  output logic                                   done,
  output logic signed [sslim_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                   last_out
);

  logic [sslim_pkg::THR_W-1:0] threshold_level;
  logic [sslim_pkg::HC_W-1:0]  hardness_code;
  logic                        q_push;
  sslim_pkg::item_t            q_push_item;
  logic                        q_full;
  logic                        q_valid;
  sslim_pkg::item_t            q_head;

  // Drop writes of zero; a hardness write with zero in its low 12 bits is dropped too.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= 16'd32768;
      hardness_code   <= 12'd1024;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sslim_pkg::REG_THRESHOLD: begin
          if (cfg_data != '0) begin
            threshold_level <= cfg_data;
          end
        end
        sslim_pkg::REG_HARDNESS: begin
          if (cfg_data[sslim_pkg::HC_W-1:0] != '0) begin
            hardness_code <= cfg_data[sslim_pkg::HC_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign busy = q_full;

  sslim_front u_front (
    .clk(clk), .rst(rst), .start(start), .q_full(q_full),
    .sample_in(sample_in), .last_in(last_in),
    .threshold_level(threshold_level), .hardness_code(hardness_code),
    .push(q_push), .push_item(q_push_item)
  );

  sslim_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_item(q_push_item),
    .pop(q_valid), .full(q_full), .valid(q_valid), .head(q_head)
  );

  sslim_back u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_item(q_head),
    .out_valid(done), .out_sample(sample_out), .out_last(last_out)
  );

  // The back end drains the queue every cycle, so it never fills.
  a_never_full: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("queue filled up");

  a_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_zero_write_ignored: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr_en && cfg_data == '0) |=> ($stable(threshold_level) && $stable(hardness_code)))
    else $error("zero write changed a setting");

endmodule
